// ----- src/rid_pkg.sv -----
package rid_pkg;

    // One character of an identity number.
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_char_item;

    // One result, delivered for the character that closes a number.
    typedef struct packed {
        logic       id_valid;
        logic [2:0] error_code;
        logic [7:0] age_years;
        logic       is_male;
    } t_result;

    // One configuration write.
    typedef struct packed {
        logic [1:0]  reg_index;
        logic [13:0] write_data;
    } t_cfg_write;

    typedef enum logic [2:0] {
        ERR_NONE   = 3'd0,
        ERR_LENGTH = 3'd1,
        ERR_CHAR   = 3'd2,
        ERR_DATE   = 3'd3,
        ERR_AGE    = 3'd4,
        ERR_CHECK  = 3'd5
    } t_err_code;

    localparam logic [1:0] REG_TODAY_YEAR  = 2'd0;
    localparam logic [1:0] REG_TODAY_MONTH = 2'd1;
    localparam logic [1:0] REG_TODAY_DAY   = 2'd2;

    localparam logic [13:0] RST_TODAY_YEAR  = 14'd2000;
    localparam logic [3:0]  RST_TODAY_MONTH = 4'd1;
    localparam logic [4:0]  RST_TODAY_DAY   = 5'd1;

    // Character positions.
    localparam logic [4:0] ID_LEN     = 5'd18;
    localparam logic [4:0] CHECK_POS  = 5'd17;
    localparam logic [4:0] SEX_POS    = 5'd16;
    localparam logic [4:0] COUNT_SAT  = 5'd19;
    localparam logic [4:0] CENT_FIRST = 5'd6;
    localparam logic [4:0] CENT_LAST  = 5'd7;
    localparam logic [4:0] YR2_FIRST  = 5'd8;
    localparam logic [4:0] YR2_LAST   = 5'd9;
    localparam logic [4:0] MON_FIRST  = 5'd10;
    localparam logic [4:0] MON_LAST   = 5'd11;
    localparam logic [4:0] DAY_FIRST  = 5'd12;
    localparam logic [4:0] DAY_LAST   = 5'd13;

    localparam logic [7:0] CHAR_0    = 8'h30;
    localparam logic [7:0] CHAR_9    = 8'h39;
    localparam logic [7:0] CHAR_X_UP = 8'h58;
    localparam logic [7:0] CHAR_X_LO = 8'h78;
    localparam logic [3:0] CHECK_X   = 4'd10;

    localparam logic [13:0] YEAR_MAX  = 14'd9999;
    localparam logic [3:0]  MONTH_MAX = 4'd12;

    // Reciprocals: x/11 for x < 227, x/100 for x < 43690, x/365 for x < 1.8M.
    localparam logic [7:0]  RECIP_11  = 8'd187;
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam logic [15:0] RECIP_365 = 16'd45965;

    // Day differences that give ages 0..150 after truncation toward zero.
    localparam logic signed [22:0] DIFF_LOW  = -23'sd364;
    localparam logic signed [22:0] DIFF_HIGH = 23'sd55114;

    function automatic logic [3:0] weight(input logic [4:0] pos);
        logic [3:0] w;
        case (pos)
            5'd0:    w = 4'd7;
            5'd1:    w = 4'd9;
            5'd2:    w = 4'd10;
            5'd3:    w = 4'd5;
            5'd4:    w = 4'd8;
            5'd5:    w = 4'd4;
            5'd6:    w = 4'd2;
            5'd7:    w = 4'd1;
            5'd8:    w = 4'd6;
            5'd9:    w = 4'd3;
            5'd10:   w = 4'd7;
            5'd11:   w = 4'd9;
            5'd12:   w = 4'd10;
            5'd13:   w = 4'd5;
            5'd14:   w = 4'd8;
            5'd15:   w = 4'd4;
            5'd16:   w = 4'd2;
            default: w = 4'd0;
        endcase
        return w;
    endfunction

    function automatic logic [3:0] check_code(input logic [3:0] sum);
        logic [3:0] c;
        case (sum)
            4'd0:    c = 4'd1;
            4'd1:    c = 4'd0;
            4'd2:    c = CHECK_X;
            4'd3:    c = 4'd9;
            4'd4:    c = 4'd8;
            4'd5:    c = 4'd7;
            4'd6:    c = 4'd6;
            4'd7:    c = 4'd5;
            4'd8:    c = 4'd4;
            4'd9:    c = 4'd3;
            4'd10:   c = 4'd2;
            default: c = 4'd0;
        endcase
        return c;
    endfunction

    // Remainder mod 11 of a value up to 100.
    function automatic logic [3:0] mod11(input logic [6:0] x);
        logic [14:0] p;
        logic [3:0]  q;
        logic [6:0]  r;
        p = 15'(x) * 15'(RECIP_11);
        q = p[14:11];
        r = x - 7'(q) * 7'd11;
        return r[3:0];
    endfunction

    // Appends a decimal digit to a value of at most one digit.
    function automatic logic [6:0] dec_push(input logic [6:0] v, input logic [3:0] d);
        return 7'((v << 3) + (v << 1) + 7'(d));
    endfunction

    function automatic logic [4:0] month_days(input logic [6:0] m, input logic leap);
        logic [4:0] n;
        case (m)
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: n = 5'd31;
            7'd4, 7'd6, 7'd9, 7'd11:                     n = 5'd30;
            7'd2:    n = leap ? 5'd29 : 5'd28;
            default: n = 5'd0;
        endcase
        return n;
    endfunction

    // Days from March 1 to the first of the month, in a year that starts in March.
    function automatic logic [8:0] month_offset(input logic [6:0] m);
        logic [8:0] o;
        case (m)
            7'd1:    o = 9'd306;
            7'd2:    o = 9'd337;
            7'd3:    o = 9'd0;
            7'd4:    o = 9'd31;
            7'd5:    o = 9'd61;
            7'd6:    o = 9'd92;
            7'd7:    o = 9'd122;
            7'd8:    o = 9'd153;
            7'd9:    o = 9'd184;
            7'd10:   o = 9'd214;
            7'd11:   o = 9'd245;
            7'd12:   o = 9'd275;
            default: o = 9'd0;
        endcase
        return o;
    endfunction

    // Day number from a March-based year, its century and the day of that year.
    function automatic logic [21:0] day_num(input logic [13:0] yy, input logic [6:0] cy,
                                            input logic [8:0] doy);
        logic [21:0] y;
        y = 22'(yy);
        return y * 22'd365 + (y >> 2) - 22'(cy) + 22'(cy >> 2) + 22'(doy);
    endfunction

endpackage

// ----- src/rid_stream_if.sv -----
interface rid_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/resident_id_number_validator.sv -----
// Resident identity number validator. Characters of an 18-character identity number
// arrive as ASCII bytes on i_char, one transaction per character, and the character with
// last_char set closes the number; that character, and only that one, produces one result
// transaction on o_result. The block checks the length, that positions 0-16 are digits
// and position 17 a digit or X/x, that positions 6-13 form a valid yyyyMMdd Gregorian
// date, that the age in whole 365-day years up to the reference date lies in 0..150,
// and the ISO 7064 MOD 11-2 check character. The first failing check in that order is
// reported in error_code; age and the male flag are zero unless the number is valid.
// A character can be accepted in every cycle. A result passes through a four-stage
// date pipeline (capture, calendar split, day numbers, difference and range) and then
// the age multiply into the output register before it is presented on o_result. The
// character input stalls only while all five registers hold results and o_result is
// not ready. The reference date is written on i_cfg (index 0 year, 1 month, 2 day);
// the user must write it only while no number is in flight, as the block itself does
// not enforce this. Out-of-range reference values are clamped to the nearest legal
// date.
module resident_id_number_validator (
    input logic   i_clk,
    input logic   i_rst_n,
    rid_stream_if.sink   i_char,
    rid_stream_if.sink   i_cfg,
    rid_stream_if.source o_result
);
    import rid_pkg::*;

    // Configuration registers.
    logic [13:0] r_today_year;
    logic [3:0]  r_today_month;
    logic [4:0]  r_today_day;

    // Per-number accumulation state.
    logic [4:0] r_count,    n_count;
    logic       r_chars_ok, n_chars_ok;
    logic [3:0] r_sum,      n_sum;
    logic [6:0] r_cent,     n_cent;
    logic [6:0] r_yr2,      n_yr2;
    logic [6:0] r_month,    n_month;
    logic [6:0] r_day,      n_day;
    logic       r_sex,      n_sex;
    logic [3:0] r_chk,      n_chk;

    // Pipeline valid bits and stage enables.
    logic r_v1, r_v2, r_v3, r_v4, r_ov;
    logic en1, en2, en3, en4, en_out;
    logic char_acc, last_acc;

    t_char_item in_item;
    t_cfg_write cfg_item;
    t_result    r_out;

    assign in_item  = i_char.data;
    assign cfg_item = i_cfg.data;

    // Each stage moves on when the stage after it is empty or moving itself.
    assign en_out = !r_ov || o_result.ready;
    assign en4    = !r_v4 || en_out;
    assign en3    = !r_v3 || en4;
    assign en2    = !r_v2 || en3;
    assign en1    = !r_v1 || en2;

    assign i_char.ready = en1;
    assign char_acc     = i_char.valid && en1;
    assign last_acc     = char_acc && in_item.last_char;

    assign i_cfg.ready    = 1'b1;
    assign o_result.valid = r_ov;
    assign o_result.data  = r_out;

    // Configuration writes; an index with no register behind it is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_today_year  <= RST_TODAY_YEAR;
            r_today_month <= RST_TODAY_MONTH;
            r_today_day   <= RST_TODAY_DAY;
        end else if (i_cfg.valid) begin
            case (cfg_item.reg_index)
                REG_TODAY_YEAR:  r_today_year  <= cfg_item.write_data;
                REG_TODAY_MONTH: r_today_month <= cfg_item.write_data[3:0];
                REG_TODAY_DAY:   r_today_day   <= cfg_item.write_data[4:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Character accumulation. The digit value is weighted into a running
    // MOD 11 sum and the date digits are collected as decimal pairs.
    // ------------------------------------------------------------------
    logic       is_digit;
    logic [7:0] char_off;
    logic [3:0] digit_val;
    logic [6:0] weighted;

    always_comb begin
        is_digit  = (in_item.char_code >= CHAR_0) && (in_item.char_code <= CHAR_9);
        char_off  = in_item.char_code - CHAR_0;
        digit_val = is_digit ? char_off[3:0] : 4'd0;
        weighted  = 7'(digit_val) * 7'(weight(r_count));

        n_count    = r_count;
        n_chars_ok = r_chars_ok;
        n_sum      = r_sum;
        n_cent     = r_cent;
        n_yr2      = r_yr2;
        n_month    = r_month;
        n_day      = r_day;
        n_sex      = r_sex;
        n_chk      = r_chk;

        if (r_count < CHECK_POS) begin
            if (!is_digit) begin
                n_chars_ok = 1'b0;
            end
            n_sum = mod11(7'(r_sum) + weighted);
            if (r_count >= CENT_FIRST && r_count <= CENT_LAST) begin
                n_cent = dec_push(r_cent, digit_val);
            end else if (r_count >= YR2_FIRST && r_count <= YR2_LAST) begin
                n_yr2 = dec_push(r_yr2, digit_val);
            end else if (r_count >= MON_FIRST && r_count <= MON_LAST) begin
                n_month = dec_push(r_month, digit_val);
            end else if (r_count >= DAY_FIRST && r_count <= DAY_LAST) begin
                n_day = dec_push(r_day, digit_val);
            end
            if (r_count == SEX_POS) begin
                n_sex = digit_val[0];
            end
        end else if (r_count == CHECK_POS) begin
            if (is_digit) begin
                n_chk = digit_val;
            end else if (in_item.char_code == CHAR_X_UP || in_item.char_code == CHAR_X_LO) begin
                n_chk = CHECK_X;
            end else begin
                n_chars_ok = 1'b0;
                n_chk      = 4'd0;
            end
        end

        if (r_count < COUNT_SAT) begin
            n_count = r_count + 5'd1;
        end
    end

    // The closing character hands the number to the pipeline and clears the state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || last_acc) begin
            r_count    <= '0;
            r_chars_ok <= 1'b1;
            r_sum      <= '0;
            r_cent     <= '0;
            r_yr2      <= '0;
            r_month    <= '0;
            r_day      <= '0;
            r_sex      <= 1'b0;
            r_chk      <= '0;
        end else if (char_acc) begin
            r_count    <= n_count;
            r_chars_ok <= n_chars_ok;
            r_sum      <= n_sum;
            r_cent     <= n_cent;
            r_yr2      <= n_yr2;
            r_month    <= n_month;
            r_day      <= n_day;
            r_sex      <= n_sex;
            r_chk      <= n_chk;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture the finished number and the clamped reference date.
    // The century of the reference year comes from a reciprocal multiply.
    // ------------------------------------------------------------------
    logic [13:0] t_year_c;
    logic [3:0]  t_month_c;
    logic [4:0]  t_day_lo;
    logic [26:0] t_prod;

    always_comb begin
        if (r_today_year == 14'd0) begin
            t_year_c = 14'd1;
        end else if (r_today_year > YEAR_MAX) begin
            t_year_c = YEAR_MAX;
        end else begin
            t_year_c = r_today_year;
        end
        if (r_today_month == 4'd0) begin
            t_month_c = 4'd1;
        end else if (r_today_month > MONTH_MAX) begin
            t_month_c = MONTH_MAX;
        end else begin
            t_month_c = r_today_month;
        end
        t_day_lo = (r_today_day == 5'd0) ? 5'd1 : r_today_day;
        t_prod   = 27'(t_year_c) * 27'(RECIP_100);
    end

    logic        r_s1_len_err, r_s1_char_err, r_s1_sex;
    logic [3:0]  r_s1_sum, r_s1_chk;
    logic [6:0]  r_s1_cent, r_s1_yr2, r_s1_month, r_s1_day;
    logic [13:0] r_s1_t_year;
    logic [6:0]  r_s1_t_cent;
    logic [3:0]  r_s1_t_month;
    logic [4:0]  r_s1_t_day;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_len_err  <= (n_count != ID_LEN);
            r_s1_char_err <= !n_chars_ok;
            r_s1_sex      <= n_sex;
            r_s1_sum      <= n_sum;
            r_s1_chk      <= n_chk;
            r_s1_cent     <= n_cent;
            r_s1_yr2      <= n_yr2;
            r_s1_month    <= n_month;
            r_s1_day      <= n_day;
            r_s1_t_year   <= t_year_c;
            r_s1_t_cent   <= t_prod[25:19];
            r_s1_t_month  <= t_month_c;
            r_s1_t_day    <= t_day_lo;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: date and check-character tests, leap years, day clamp,
    // and the split into a March-based year plus the day within it.
    // ------------------------------------------------------------------
    logic [13:0] b_year, b_yy, t_rem, t_yy;
    logic        b_leap, b_jf, t_leap, t_jf, b_date_err;
    logic [4:0]  b_mdays, t_mdays, t_day_c;
    logic [6:0]  b_cy, t_yr2, t_cy, t_month7;
    logic [8:0]  b_doy, t_doy;

    always_comb begin
        b_year     = 14'(r_s1_cent) * 14'd100 + 14'(r_s1_yr2);
        b_leap     = (r_s1_yr2 != 7'd0) ? (r_s1_yr2[1:0] == 2'd0) : (r_s1_cent[1:0] == 2'd0);
        b_mdays    = month_days(r_s1_month, b_leap);
        b_date_err = (b_year == 14'd0) || (r_s1_day == 7'd0) || (r_s1_day > 7'(b_mdays));
        b_jf       = (r_s1_month == 7'd1) || (r_s1_month == 7'd2);
        b_yy       = b_year - 14'(b_jf);
        b_cy       = (b_jf && r_s1_yr2 == 7'd0) ? r_s1_cent - 7'd1 : r_s1_cent;
        b_doy      = month_offset(r_s1_month) + 9'(r_s1_day) - 9'd1;

        t_rem    = r_s1_t_year - 14'(r_s1_t_cent) * 14'd100;
        t_yr2    = t_rem[6:0];
        t_leap   = (t_yr2 != 7'd0) ? (t_yr2[1:0] == 2'd0) : (r_s1_t_cent[1:0] == 2'd0);
        t_month7 = 7'(r_s1_t_month);
        t_mdays  = month_days(t_month7, t_leap);
        t_day_c  = (r_s1_t_day > t_mdays) ? t_mdays : r_s1_t_day;
        t_jf     = (r_s1_t_month == 4'd1) || (r_s1_t_month == 4'd2);
        t_yy     = r_s1_t_year - 14'(t_jf);
        t_cy     = (t_jf && t_yr2 == 7'd0) ? r_s1_t_cent - 7'd1 : r_s1_t_cent;
        t_doy    = month_offset(t_month7) + 9'(t_day_c) - 9'd1;
    end

    logic        r_s2_len_err, r_s2_char_err, r_s2_date_err, r_s2_chk_err, r_s2_sex;
    logic [13:0] r_s2_b_yy, r_s2_t_yy;
    logic [6:0]  r_s2_b_cy, r_s2_t_cy;
    logic [8:0]  r_s2_b_doy, r_s2_t_doy;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_len_err  <= r_s1_len_err;
            r_s2_char_err <= r_s1_char_err;
            r_s2_date_err <= b_date_err;
            r_s2_chk_err  <= (check_code(r_s1_sum) != r_s1_chk);
            r_s2_sex      <= r_s1_sex;
            r_s2_b_yy     <= b_yy;
            r_s2_b_cy     <= b_cy;
            r_s2_b_doy    <= b_doy;
            r_s2_t_yy     <= t_yy;
            r_s2_t_cy     <= t_cy;
            r_s2_t_doy    <= t_doy;
        end
    end

    // Stage 3: absolute day numbers of the birth date and the reference date.
    logic        r_s3_len_err, r_s3_char_err, r_s3_date_err, r_s3_chk_err, r_s3_sex;
    logic [21:0] r_s3_dn_b, r_s3_dn_t;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_len_err  <= r_s2_len_err;
            r_s3_char_err <= r_s2_char_err;
            r_s3_date_err <= r_s2_date_err;
            r_s3_chk_err  <= r_s2_chk_err;
            r_s3_sex      <= r_s2_sex;
            r_s3_dn_b     <= day_num(r_s2_b_yy, r_s2_b_cy, r_s2_b_doy);
            r_s3_dn_t     <= day_num(r_s2_t_yy, r_s2_t_cy, r_s2_t_doy);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: day difference, age range and the error code. A birth date
    // less than a year in the future still counts as age zero.
    // ------------------------------------------------------------------
    logic signed [22:0] day_diff;
    logic               age_err;
    t_err_code          err_sel;

    always_comb begin
        day_diff = $signed({1'b0, r_s3_dn_t}) - $signed({1'b0, r_s3_dn_b});
        age_err  = (day_diff < DIFF_LOW) || (day_diff > DIFF_HIGH);
        if (r_s3_len_err) begin
            err_sel = ERR_LENGTH;
        end else if (r_s3_char_err) begin
            err_sel = ERR_CHAR;
        end else if (r_s3_date_err) begin
            err_sel = ERR_DATE;
        end else if (age_err) begin
            err_sel = ERR_AGE;
        end else if (r_s3_chk_err) begin
            err_sel = ERR_CHECK;
        end else begin
            err_sel = ERR_NONE;
        end
    end

    t_err_code   r_s4_err;
    logic [15:0] r_s4_days;
    logic        r_s4_sex;

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_s4_err  <= err_sel;
            r_s4_days <= day_diff[22] ? 16'd0 : day_diff[15:0];
            r_s4_sex  <= r_s3_sex;
        end
    end

    // Output stage: whole years by a reciprocal multiply, then the result register.
    logic [31:0] age_prod;
    logic        res_ok;

    always_comb begin
        age_prod = 32'(r_s4_days) * 32'(RECIP_365);
        res_ok   = (r_s4_err == ERR_NONE);
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out.id_valid   <= res_ok;
            r_out.error_code <= r_s4_err;
            r_out.age_years  <= res_ok ? age_prod[31:24] : 8'd0;
            r_out.is_male    <= res_ok && r_s4_sex;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= last_acc;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
            if (en_out) begin
                r_ov <= r_v4;
            end
        end
    end

`ifndef SYNTHESIS
    // A closing character always enters the date pipeline.
    a_last_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last_acc |=> r_v1)
        else $error("closing character did not enter the pipeline");

    // A closing character leaves the accumulation state cleared.
    a_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last_acc |=> (r_count == 5'd0 && r_chars_ok && r_sum == 4'd0))
        else $error("number state not cleared after closing character");

    // A rejected number carries an error code and no age or sex.
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.data.id_valid) |->
            (o_result.data.error_code != ERR_NONE && o_result.data.age_years == 8'd0 &&
             !o_result.data.is_male))
        else $error("rejected number has inconsistent result fields");

    // An accepted number never reports an age above the limit.
    a_age_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.data.id_valid) |->
            (o_result.data.error_code == ERR_NONE && o_result.data.age_years <= 8'd150))
        else $error("accepted number has age out of range");
`endif

endmodule

// ----- tb/resident_id_number_validator_tb.sv -----
// Self-checking bench for resident_id_number_validator.
module resident_id_number_validator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rid_pkg::*;

    // Age arithmetic, kept separate from the positions the package supplies.
    localparam int DAYS_PER_YEAR = 365;
    localparam int MAX_AGE       = 150;
    localparam int ID_MOD        = 11;

    // Index 3 is not a register; writes to it must leave the reference date alone.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // Number of random characters to push through after the directed tests.
    localparam int RANDOM_CHARS = 100;

    // Settling time after the last expected result, longer than the trip of a result
    // through the five registers inside the block.
    localparam int SETTLE_CYCLES = 10;

    logic i_clk;
    logic i_rst_n;

    rid_stream_if #(.T(t_char_item)) char_if ();
    rid_stream_if #(.T(t_cfg_write)) cfg_if ();
    rid_stream_if #(.T(t_result))    res_if ();

    resident_id_number_validator dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (char_if.sink),
        .i_cfg    (cfg_if.sink),
        .o_result (res_if.source)
    );

    // ------------------------------------------------------------------
    // Shared bench state.
    // ------------------------------------------------------------------

    // Verdicts that the block still owes, oldest first.
    t_result     pending_verdicts[$];
    int unsigned mismatches;
    int unsigned items_sent;

    // Characters of the number about to be sent.
    logic [7:0]  id_chars[$];

    // Sender pacing: a burst counter, and a switch that turns idling off.
    int unsigned burst_left;
    bit          steady_sender;

    // A nonzero value asks the receiver to hold off for that many cycles.
    int unsigned hold_request;

    // ------------------------------------------------------------------
    // Predictor: a private copy of the reference date and of the number
    // being assembled, updated on every accepted transaction.
    // ------------------------------------------------------------------
    int unsigned ref_year;
    int unsigned ref_mon;
    int unsigned ref_day;

    int unsigned char_pos;
    bit          digits_ok;
    int unsigned weight_sum;
    int unsigned birth_y;
    int unsigned birth_m;
    int unsigned birth_d;
    bit          sex_odd;
    int unsigned check_val;

    // The MOD 11-2 weight of a position is 2 raised to its distance from the
    // check position, reduced mod 11.
    function automatic int unsigned pos_weight(input int unsigned p);
        int unsigned w;
        int unsigned k;
        w = 1;
        for (k = p; k < CHECK_POS; k++) begin
            w = (w * 2) % ID_MOD;
        end
        return w;
    endfunction

    // Check value demanded by a weighted sum; 10 stands for X.
    function automatic int unsigned check_value(input int unsigned sum);
        return (12 - sum) % ID_MOD;
    endfunction

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap_year(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    // Days since the start of the Gregorian calendar; only differences matter.
    function automatic longint serial_day(input int unsigned y, input int unsigned m,
                                          input int unsigned d);
        longint      n;
        int unsigned p;
        int unsigned k;
        p = y - 1;
        n = longint'(365 * p) + longint'(p / 4) - longint'(p / 100) + longint'(p / 400);
        for (k = 1; k < m; k++) begin
            n = n + longint'(days_in_month(y, k));
        end
        return n + longint'(d);
    endfunction

    // The reference date after clamping into a legal calendar date.
    function automatic void clamp_reference(output int unsigned y, output int unsigned m,
                                            output int unsigned d);
        y = ref_year;
        if (y < 1) y = 1;
        if (y > YEAR_MAX) y = YEAR_MAX;
        m = ref_mon;
        if (m < 1) m = 1;
        if (m > MONTH_MAX) m = MONTH_MAX;
        d = ref_day;
        if (d < 1) d = 1;
        if (d > days_in_month(y, m)) d = days_in_month(y, m);
    endfunction

    function automatic void clear_number();
        char_pos   = 0;
        digits_ok  = 1'b1;
        weight_sum = 0;
        birth_y    = 0;
        birth_m    = 0;
        birth_d    = 0;
        sex_odd    = 1'b0;
        check_val  = 0;
    endfunction

    function automatic void apply_reg_write(input logic [1:0] idx, input logic [13:0] val);
        case (idx)
            REG_TODAY_YEAR:  ref_year = val;
            REG_TODAY_MONTH: ref_mon  = val[3:0];
            REG_TODAY_DAY:   ref_day  = val[4:0];
            default: ;
        endcase
    endfunction

    // Folds one character into the number. Returns 1 with the verdict filled in
    // when the character closes the number.
    function automatic bit validate_char(input logic [7:0] code, input logic closing,
                                         output t_result verdict);
        int unsigned dv;
        int unsigned ry;
        int unsigned rm;
        int unsigned rd;
        int unsigned age_val;
        bit          is_digit;
        longint      span;
        longint      years;
        t_err_code   err;

        verdict  = '0;
        is_digit = (code >= CHAR_0) && (code <= CHAR_9);
        dv       = is_digit ? int'(code - CHAR_0) : 0;

        if (char_pos < CHECK_POS) begin
            if (!is_digit) digits_ok = 1'b0;
            weight_sum = (weight_sum + dv * pos_weight(char_pos)) % ID_MOD;
            if (char_pos >= CENT_FIRST && char_pos <= YR2_LAST) begin
                birth_y = birth_y * 10 + dv;
            end else if (char_pos >= MON_FIRST && char_pos <= MON_LAST) begin
                birth_m = birth_m * 10 + dv;
            end else if (char_pos >= DAY_FIRST && char_pos <= DAY_LAST) begin
                birth_d = birth_d * 10 + dv;
            end
            if (char_pos == SEX_POS) sex_odd = dv[0];
        end else if (char_pos == CHECK_POS) begin
            if (is_digit) begin
                check_val = dv;
            end else if (code == CHAR_X_UP || code == CHAR_X_LO) begin
                check_val = CHECK_X;
            end else begin
                digits_ok = 1'b0;
                check_val = 0;
            end
        end
        if (char_pos < COUNT_SAT) char_pos++;

        if (!closing) return 1'b0;

        err     = ERR_NONE;
        age_val = 0;
        if (char_pos != ID_LEN) begin
            err = ERR_LENGTH;
        end else if (!digits_ok) begin
            err = ERR_CHAR;
        end else if (birth_y < 1 || birth_y > YEAR_MAX || birth_d < 1 ||
                     birth_d > days_in_month(birth_y, birth_m)) begin
            err = ERR_DATE;
        end else begin
            clamp_reference(ry, rm, rd);
            span  = serial_day(ry, rm, rd) - serial_day(birth_y, birth_m, birth_d);
            // Signed division truncates toward zero, so a birth date up to 364 days
            // in the future still counts as age zero.
            years = span / DAYS_PER_YEAR;
            if (years < 0 || years > MAX_AGE) begin
                err = ERR_AGE;
            end else if (check_value(weight_sum) != check_val) begin
                err = ERR_CHECK;
            end else begin
                age_val = int'(years);
            end
        end

        verdict.id_valid   = (err == ERR_NONE);
        verdict.error_code = err;
        verdict.age_years  = (err == ERR_NONE) ? age_val[7:0] : 8'd0;
        verdict.is_male    = (err == ERR_NONE) ? sex_odd : 1'b0;
        clear_number();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Number construction.
    // ------------------------------------------------------------------

    // Builds a well-formed number around a birth date: random region and sequence
    // digits, the date in positions 6-13, and the matching check character.
    function automatic void build_id(input int unsigned y, input int unsigned m,
                                     input int unsigned d);
        int unsigned sum;
        int unsigned cv;
        int unsigned i;
        id_chars.delete();
        repeat (6) id_chars.push_back(8'(CHAR_0 + $urandom_range(0, 9)));
        y = y % 10000;
        m = m % 100;
        d = d % 100;
        id_chars.push_back(8'(CHAR_0 + y / 1000));
        id_chars.push_back(8'(CHAR_0 + (y / 100) % 10));
        id_chars.push_back(8'(CHAR_0 + (y / 10) % 10));
        id_chars.push_back(8'(CHAR_0 + y % 10));
        id_chars.push_back(8'(CHAR_0 + m / 10));
        id_chars.push_back(8'(CHAR_0 + m % 10));
        id_chars.push_back(8'(CHAR_0 + d / 10));
        id_chars.push_back(8'(CHAR_0 + d % 10));
        repeat (3) id_chars.push_back(8'(CHAR_0 + $urandom_range(0, 9)));
        sum = 0;
        for (i = 0; i < CHECK_POS; i++) begin
            sum = (sum + (id_chars[i] - CHAR_0) * pos_weight(i)) % ID_MOD;
        end
        cv = check_value(sum);
        if (cv == CHECK_X) begin
            id_chars.push_back($urandom_range(0, 1) ? CHAR_X_UP : CHAR_X_LO);
        end else begin
            id_chars.push_back(8'(CHAR_0 + cv));
        end
    endfunction

    // Rebuilds until the check character comes out as X (about one try in eleven).
    function automatic void build_id_x(input int unsigned y, input int unsigned m,
                                       input int unsigned d);
        do begin
            build_id(y, m, d);
        end while (id_chars[CHECK_POS] != CHAR_X_UP && id_chars[CHECK_POS] != CHAR_X_LO);
    endfunction

    // Replaces the check character with one that cannot match.
    function automatic void spoil_check();
        logic [7:0] c;
        c = id_chars[CHECK_POS];
        if (c >= CHAR_0 && c < CHAR_9) id_chars[CHECK_POS] = c + 8'd1;
        else id_chars[CHECK_POS] = CHAR_0;
    endfunction

    function automatic void fill_digits(input int unsigned n);
        id_chars.delete();
        repeat (n) id_chars.push_back(8'(CHAR_0 + $urandom_range(0, 9)));
    endfunction

    // ------------------------------------------------------------------
    // Drivers.
    // ------------------------------------------------------------------

    // Offers one character and waits for its transaction. Valid is left high on
    // return so that a following character goes out in the very next cycle; gaps
    // between bursts lower it.
    task automatic send_char(input logic [7:0] code, input logic closing);
        t_char_item item;
        t_result    verdict;
        int unsigned gap;
        if (!steady_sender && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            char_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0) burst_left--;
        item.char_code = code;
        item.last_char = closing;
        char_if.data  <= item;
        char_if.valid <= 1'b1;
        @(posedge i_clk);
        while (!char_if.ready) @(posedge i_clk);
        items_sent++;
        if (validate_char(code, closing, verdict)) pending_verdicts.push_back(verdict);
    endtask

    // Sends the characters in id_chars, the final one flagged as last.
    task automatic send_id();
        for (int i = 0; i < id_chars.size(); i++) begin
            send_char(id_chars[i], i == id_chars.size() - 1);
        end
    endtask

    // Writes one register; the caller lowers valid after its last write.
    task automatic write_reg(input logic [1:0] idx, input logic [13:0] val);
        t_cfg_write wr;
        wr.reg_index   = idx;
        wr.write_data  = val;
        cfg_if.data   <= wr;
        cfg_if.valid  <= 1'b1;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        apply_reg_write(idx, val);
    endtask

    task automatic set_reference(input logic [13:0] y, input logic [13:0] m,
                                 input logic [13:0] d);
        write_reg(REG_TODAY_YEAR, y);
        write_reg(REG_TODAY_MONTH, m);
        write_reg(REG_TODAY_DAY, d);
        cfg_if.valid <= 1'b0;
    endtask

    // Lets the block drain: every owed verdict arrives, then a few quiet cycles
    // so nothing is still in flight before the reference date changes.
    task automatic settle();
        char_if.valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One random number. Most are well formed with a birth date near the
    // reference date so that the age and check-digit stages are reached; the
    // rest carry wrong check characters, corrupted positions, odd lengths or
    // plain byte noise.
    task automatic random_number();
        int unsigned kind;
        int unsigned ry;
        int unsigned rm;
        int unsigned rd;
        int unsigned y;
        int unsigned m;
        int unsigned d;
        int unsigned n;
        kind = $urandom_range(0, 99);
        clamp_reference(ry, rm, rd);
        if ($urandom_range(0, 9) == 0) y = $urandom_range(0, 9999);
        else if (ry > 160) y = ry - $urandom_range(0, 160);
        else y = $urandom_range(1, ry + 1);
        m = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 12) : $urandom_range(0, 99);
        d = ($urandom_range(0, 7) != 0) ? $urandom_range(1, 31) : $urandom_range(0, 99);
        build_id(y, m, d);
        if (kind >= 60 && kind < 70) begin
            spoil_check();
        end else if (kind >= 70 && kind < 85) begin
            case ($urandom_range(0, 2))
                0: id_chars[$urandom_range(0, CHECK_POS)] = 8'($urandom_range(0, 255));
                1: begin
                    n = $urandom_range(1, CHECK_POS);
                    while (id_chars.size() > n) void'(id_chars.pop_back());
                end
                default: repeat ($urandom_range(1, 4))
                    id_chars.push_back(8'(CHAR_0 + $urandom_range(0, 9)));
            endcase
        end else if (kind >= 85) begin
            id_chars.delete();
            repeat ($urandom_range(1, 22)) id_chars.push_back(8'($urandom_range(0, 255)));
        end
        send_id();
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Valid numbers against the reset reference date, including an uppercase
    // and a lowercase X as check character.
    task automatic test_valid_numbers();
        build_id(1985, 7, 23);
        send_id();
        build_id_x(1962, 11, 5);
        id_chars[CHECK_POS] = CHAR_X_UP;
        send_id();
        build_id_x(1999, 12, 31);
        id_chars[CHECK_POS] = CHAR_X_LO;
        send_id();
    endtask

    // Wrong lengths: a lone closing character, one short, one long, and long
    // enough for the position count to saturate.
    task automatic test_length();
        fill_digits(1);
        send_id();
        fill_digits(CHECK_POS);
        send_id();
        fill_digits(COUNT_SAT);
        send_id();
        fill_digits(25);
        send_id();
    endtask

    // Characters outside the allowed set, just either side of the digit range
    // and with the top bit set, plus a check character that is not X.
    task automatic test_bad_chars();
        build_id(1980, 1, 1);
        id_chars[0] = 8'h41;
        send_id();
        build_id(1980, 1, 1);
        id_chars[9] = CHAR_0 - 8'd1;
        send_id();
        build_id(1980, 1, 1);
        id_chars[SEX_POS] = CHAR_9 + 8'd1;
        send_id();
        build_id(1980, 1, 1);
        id_chars[3] = 8'hFF;
        send_id();
        build_id(1980, 1, 1);
        id_chars[CHECK_POS] = 8'h59;
        send_id();
    endtask

    // Calendar rules: year zero, month zero and thirteen, day zero, a century
    // that is not a leap year, an ordinary leap year, and a short month overrun.
    task automatic test_bad_dates();
        build_id(0, 5, 5);
        send_id();
        build_id(1990, 0, 10);
        send_id();
        build_id(1990, 13, 10);
        send_id();
        build_id(1990, 5, 0);
        send_id();
        build_id(1900, 2, 29);
        send_id();
        build_id(1996, 2, 29);
        send_id();
        build_id(1990, 4, 31);
        send_id();
    endtask

    // Age limits around the reset reference date of 2000-01-01: just inside
    // and beyond 150 years, and a birth 364 and 365 days in the future.
    task automatic test_age_range();
        build_id(1850, 3, 1);
        send_id();
        build_id(1849, 1, 1);
        send_id();
        build_id(2000, 12, 30);
        send_id();
        build_id(2000, 12, 31);
        send_id();
    endtask

    task automatic test_check_digit();
        build_id(1975, 6, 15);
        spoil_check();
        send_id();
    endtask

    // Reference date extremes, out-of-range values that the block clamps, and a
    // write to the unused index that must change nothing.
    task automatic test_reference_date();
        settle();
        set_reference(14'd0, 14'd0, 14'd0);
        repeat (2) random_number();
        settle();
        set_reference(14'h3FFF, 14'd15, 14'd31);
        repeat (2) random_number();
        settle();
        set_reference(14'd2024, 14'd2, 14'd31);
        repeat (2) random_number();
        settle();
        set_reference(14'd9999, 14'd12, 14'd31);
        build_id(9849, 1, 1);
        send_id();
        random_number();
        settle();
        set_reference(14'd1, 14'd1, 14'd1);
        build_id(1, 1, 1);
        send_id();
        random_number();
        settle();
        write_reg(REG_TODAY_YEAR, 14'd2010);
        write_reg(REG_UNUSED, 14'($urandom_range(0, 16383)));
        write_reg(REG_TODAY_MONTH, 14'd6);
        write_reg(REG_TODAY_DAY, 14'd15);
        cfg_if.valid <= 1'b0;
        repeat (2) random_number();
        settle();
    endtask

    // The receiver holds off for a long stretch while the sender keeps going
    // without gaps; a run of one-character numbers produces a result every
    // cycle, so the output backs up and the character input must stall.
    task automatic test_backpressure();
        steady_sender = 1'b1;
        hold_request  = 150;
        repeat (40) begin
            fill_digits(1);
            send_id();
        end
        build_id(1970, 3, 3);
        send_id();
        fill_digits(1);
        send_id();
        steady_sender = 1'b0;
        settle();
    endtask

    // Random phases, each under a fresh reference date, until enough random
    // characters have gone through.
    task automatic test_random();
        int unsigned first_item;
        first_item = items_sent;
        while (items_sent - first_item < RANDOM_CHARS) begin
            settle();
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: write_reg(REG_TODAY_YEAR, 14'($urandom_range(1950, 2100)));
                7, 8: write_reg(REG_TODAY_YEAR, 14'($urandom_range(1, 9999)));
                default: write_reg(REG_TODAY_YEAR, 14'($urandom_range(0, 16383)));
            endcase
            write_reg(REG_TODAY_MONTH, 14'($urandom_range(0, 15)));
            write_reg(REG_TODAY_DAY, 14'($urandom_range(0, 31)));
            if ($urandom_range(0, 4) == 0) write_reg(REG_UNUSED, 14'($urandom_range(0, 16383)));
            cfg_if.valid <= 1'b0;
            steady_sender = ($urandom_range(0, 3) == 0);
            repeat (6) random_number();
        end
        steady_sender = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Checking.
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Every result transaction is matched against the oldest owed verdict.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = res_if.data;
            if (pending_verdicts.size() == 0) begin
                report_mismatch("unexpected result, error_code", got.error_code, 0);
            end else begin
                want = pending_verdicts.pop_front();
                if (got.id_valid !== want.id_valid)
                    report_mismatch("id_valid", got.id_valid, want.id_valid);
                if (got.error_code !== want.error_code)
                    report_mismatch("error_code", got.error_code, want.error_code);
                if (got.age_years !== want.age_years)
                    report_mismatch("age_years", got.age_years, want.age_years);
                if (got.is_male !== want.is_male)
                    report_mismatch("is_male", got.is_male, want.is_male);
            end
        end
    end

    // ------------------------------------------------------------------
    // Clock, receiver and run control.
    // ------------------------------------------------------------------

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Receiver: the stall rate changes between none, light and heavy, and a
    // hold-off request forces ready low for the requested count.
    initial begin
        int unsigned cyc;
        int unsigned stall_pct;
        int unsigned hold_left;
        res_if.ready = 1'b0;
        cyc          = 0;
        stall_pct    = 0;
        hold_left    = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (cyc % 48 == 0) begin
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 30;
                    default: stall_pct = 75;
                endcase
            end
            cyc++;
            if (hold_left != 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Upper bound on the run; a correct run finishes far sooner.
    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        char_if.valid = 1'b0;
        char_if.data  = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.data   = '0;
        mismatches    = 0;
        items_sent    = 0;
        burst_left    = 0;
        steady_sender = 1'b0;
        hold_request  = 0;
        ref_year      = RST_TODAY_YEAR;
        ref_mon       = RST_TODAY_MONTH;
        ref_day       = RST_TODAY_DAY;
        clear_number();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_valid_numbers();
        test_length();
        test_bad_chars();
        test_bad_dates();
        test_age_range();
        test_check_digit();
        test_reference_date();
        test_backpressure();
        test_random();

        // Drain every owed verdict, then watch a few more cycles for strays.
        settle();

        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/rid_pkg.sv
src/rid_stream_if.sv
src/resident_id_number_validator.sv
tb/resident_id_number_validator_tb.sv
